/* rtl/sws_pkg.sv */
package sws_pkg;

    localparam int unsigned SEGMENT_BYTES = 1024;
    localparam int unsigned HEADER_BYTES  = 11;
    localparam int unsigned PAYLOAD_MAX   = SEGMENT_BYTES - HEADER_BYTES;

    localparam int unsigned ID_W      = 16;
    localparam int unsigned LEN_W     = 16;
    localparam int unsigned SENT_W    = 17;
    localparam int unsigned PAYLOAD_W = 10;
    localparam int unsigned SEGLEN_W  = 11;

    localparam logic [SENT_W-1:0] PAYLOAD_MAX_S  = SENT_W'(PAYLOAD_MAX);
    localparam logic [SENT_W-1:0] HEADER_BYTES_S = SENT_W'(HEADER_BYTES);

    typedef enum logic {
        MODE_START = 1'b0,
        MODE_ACK   = 1'b1
    } t_mode;

    typedef enum logic [1:0] {
        KIND_SEND      = 2'd0,
        KIND_WRONG_ACK = 2'd1,
        KIND_DONE      = 2'd2,
        KIND_REFUSED   = 2'd3
    } t_kind;

    typedef struct packed {
        t_mode             mode;
        logic [LEN_W-1:0]  message_length;
        logic [ID_W-1:0]   acked_segment;
    } t_item;

    typedef struct packed {
        t_kind                kind;
        logic [ID_W-1:0]      packet_number;
        logic [ID_W-1:0]      segment_number;
        logic [ID_W-1:0]      fragment_number;
        logic [LEN_W-1:0]     payload_offset;
        logic [PAYLOAD_W-1:0] payload_bytes;
        logic [SEGLEN_W-1:0]  segment_bytes;
        logic                 final_segment;
        logic                 fragmented;
    } t_result;

endpackage

/* rtl/stop_and_wait_segmenter.sv */
// Sender side of a stop-and-wait link with segmentation. Every accepted input transaction,
// a start or an acknowledgement, yields exactly one result transaction: a segment
// descriptor, a wrong-acknowledgement report, a message-complete notice or a refusal.
// The block takes one transaction per clock cycle while its output side is not stalled;
// a transaction is registered in the input register on entry, evaluated combinationally
// against the protocol state and held in the result register, from which its result is
// presented and can be taken when the output side is not stalled.
// A stalled output holds one result while one further input transaction waits in the
// input register.
module stop_and_wait_segmenter
    import sws_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_mode,
    input  logic [LEN_W-1:0]     i_message_length,
    input  logic [ID_W-1:0]      i_acked_segment,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [1:0]           o_kind,
    output logic [ID_W-1:0]      o_packet_number,
    output logic [ID_W-1:0]      o_segment_number,
    output logic [ID_W-1:0]      o_fragment_number,
    output logic [LEN_W-1:0]     o_payload_offset,
    output logic [PAYLOAD_W-1:0] o_payload_bytes,
    output logic [SEGLEN_W-1:0]  o_segment_bytes,
    output logic                 o_final_segment,
    output logic                 o_fragmented
);

    t_item   in_item;
    t_item   held_item;
    logic    held_valid;
    logic    advance;
    t_result next_result;
    t_result out_result;

    assign in_item.mode           = t_mode'(i_mode);
    assign in_item.message_length = i_message_length;
    assign in_item.acked_segment  = i_acked_segment;

    assign advance = held_valid && (!o_out_valid || i_out_ready);

    sws_in_reg u_in_reg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_item    (in_item),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_item    (held_item)
    );

    sws_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (held_item),
        .o_result  (next_result)
    );

    sws_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance),
        .i_result (next_result),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (out_result)
    );

    assign o_kind            = out_result.kind;
    assign o_packet_number   = out_result.packet_number;
    assign o_segment_number  = out_result.segment_number;
    assign o_fragment_number = out_result.fragment_number;
    assign o_payload_offset  = out_result.payload_offset;
    assign o_payload_bytes   = out_result.payload_bytes;
    assign o_segment_bytes   = out_result.segment_bytes;
    assign o_final_segment   = out_result.final_segment;
    assign o_fragmented      = out_result.fragmented;

endmodule

/* rtl/sws_in_reg.sv */
module sws_in_reg
    import sws_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    input  logic  i_advance,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

/* rtl/sws_core.sv */
module sws_core
    import sws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_item   i_item,
    output t_result o_result
);

    logic [ID_W-1:0]   r_next_segment_id, n_next_segment_id;
    logic [ID_W-1:0]   r_packet_counter,  n_packet_counter;
    logic [ID_W-1:0]   r_fragment_index,  n_fragment_index;
    logic [SENT_W-1:0] r_bytes_sent,      n_bytes_sent;
    logic [LEN_W-1:0]  r_total_length,    n_total_length;
    logic              r_split_flag,      n_split_flag;
    logic              r_awaiting_ack,    n_awaiting_ack;
    logic              r_on_last,         n_on_last;

    always_comb begin
        logic              do_emit;
        logic [SENT_W-1:0] total;
        logic [SENT_W-1:0] remaining;
        logic [SENT_W-1:0] size;
        logic [SENT_W-1:0] seg_len;
        logic              last;

        n_next_segment_id = r_next_segment_id;
        n_packet_counter  = r_packet_counter;
        n_fragment_index  = r_fragment_index;
        n_bytes_sent      = r_bytes_sent;
        n_total_length    = r_total_length;
        n_split_flag      = r_split_flag;
        n_awaiting_ack    = r_awaiting_ack;
        n_on_last         = r_on_last;
        o_result          = '0;
        o_result.kind     = KIND_REFUSED;
        do_emit           = 1'b0;

        unique case (i_item.mode)
            MODE_START: begin
                if (r_awaiting_ack) begin
                    o_result.kind = KIND_REFUSED;
                end else if (i_item.message_length == '0) begin
                    o_result.kind          = KIND_DONE;
                    o_result.packet_number = r_packet_counter;
                    n_packet_counter       = r_packet_counter + 1'b1;
                    n_awaiting_ack         = 1'b0;
                    n_on_last              = 1'b0;
                end else begin
                    n_total_length   = i_item.message_length;
                    n_bytes_sent     = '0;
                    n_fragment_index = '0;
                    n_split_flag     = SENT_W'(i_item.message_length) > PAYLOAD_MAX_S;
                    do_emit          = 1'b1;
                end
            end
            MODE_ACK: begin
                if (!r_awaiting_ack) begin
                    o_result.kind = KIND_REFUSED;
                end else if (i_item.acked_segment != r_next_segment_id) begin
                    o_result.kind           = KIND_WRONG_ACK;
                    o_result.packet_number  = r_packet_counter;
                    o_result.segment_number = r_next_segment_id;
                end else begin
                    n_next_segment_id = r_next_segment_id + 1'b1;
                    n_fragment_index  = r_fragment_index + 1'b1;
                    if (r_on_last) begin
                        n_bytes_sent           = '0;
                        o_result.kind          = KIND_DONE;
                        o_result.packet_number = r_packet_counter;
                        n_packet_counter       = r_packet_counter + 1'b1;
                        n_awaiting_ack         = 1'b0;
                        n_on_last              = 1'b0;
                    end else begin
                        n_bytes_sent = r_bytes_sent + PAYLOAD_MAX_S;
                        do_emit      = 1'b1;
                    end
                end
            end
            default: begin
                o_result.kind = KIND_REFUSED;
            end
        endcase

        total     = SENT_W'(n_total_length);
        remaining = (n_bytes_sent >= total) ? '0 : total - n_bytes_sent;
        last      = remaining <= PAYLOAD_MAX_S;
        size      = last ? remaining : PAYLOAD_MAX_S;
        seg_len   = size + HEADER_BYTES_S;

        if (do_emit) begin
            n_on_last                = last;
            n_awaiting_ack           = 1'b1;
            o_result.kind            = KIND_SEND;
            o_result.packet_number   = r_packet_counter;
            o_result.segment_number  = n_next_segment_id;
            o_result.fragment_number = n_fragment_index;
            o_result.payload_offset  = n_bytes_sent[LEN_W-1:0];
            o_result.payload_bytes   = size[PAYLOAD_W-1:0];
            o_result.segment_bytes   = seg_len[SEGLEN_W-1:0];
            o_result.final_segment   = last;
            o_result.fragmented      = n_split_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_segment_id <= '0;
            r_packet_counter  <= '0;
            r_fragment_index  <= '0;
            r_bytes_sent      <= '0;
            r_total_length    <= '0;
            r_split_flag      <= 1'b0;
            r_awaiting_ack    <= 1'b0;
            r_on_last         <= 1'b0;
        end else if (i_advance) begin
            r_next_segment_id <= n_next_segment_id;
            r_packet_counter  <= n_packet_counter;
            r_fragment_index  <= n_fragment_index;
            r_bytes_sent      <= n_bytes_sent;
            r_total_length    <= n_total_length;
            r_split_flag      <= n_split_flag;
            r_awaiting_ack    <= n_awaiting_ack;
            r_on_last         <= n_on_last;
        end
    end

endmodule

/* rtl/sws_out_reg.sv */
module sws_out_reg
    import sws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
